### sv/jss_pkg.sv
// ----------------------------------------------------------------------------
// Jump search sorted table: shared package
// Sizes, operation codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_KEY_WIDTH   = 32;

    // Fixed widths of the ports.
    localparam int COUNT_W   = 11;
    localparam int ADDR_W    = 10;
    localparam int KEY_IN_W  = 32;
    localparam int MAX_KEY_W = 64;

    // The entry count never exceeds 2047, so its square root fits in six bits.
    localparam int ROOT_W    = 6;
    localparam int ROOT_BIT_W = 3;
    // Block limits run up to the count plus one stride.
    localparam int LIMIT_W   = 12;

    // Operation codes of an input transaction.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic write;       // store the incoming key in the table
        logic start;       // capture the search key and clear the root
        logic sqrt_step;   // one bit of the square root
        logic jump_init;   // first block limit is the stride, base is zero
        logic rd_scan;     // read at the base rather than at the block end
        logic jump_adv;    // move to the next block
        logic scan_adv;    // move to the next entry within the block
        logic res_hit;     // result is a match at the base
        logic res_miss;    // result is not found
        logic out_load;    // copy the result into the output register
    } cmd_t;

    typedef struct packed {
        logic empty;       // no entries in use
        logic sqrt_last;   // final square root bit is being decided
        logic less;        // entry read is below the search key
        logic equal;       // entry read equals the search key
        logic limit_ge_n;  // current block limit reaches the entry count
        logic scan_end;    // next entry would leave the current block
    } status_t;

endpackage

### sv/jump_search_sorted_table.sv
// ----------------------------------------------------------------------------
// Jump search sorted table: top level
// A table of keys in ascending order, loaded one entry at a time, searched
// by jump search with a step of the integer square root of the entry count.
// ----------------------------------------------------------------------------
// Usage.
// The input channel (in_valid, in_stall) carries one transaction per item:
// operation selects a write, which stores key at entry_address, or a search
// for key. A write produces no result; a write to an
// address at or beyond the table depth is dropped. A search produces one
// result transaction on the output channel (out_valid, out_stall): found and
// position, the matching index or on a miss the entry count capped at depth.
// The configuration channel (cfg_valid, cfg_ready) sets entry_count; it is
// always ready and must only be written while no search is in flight.
// A search of n entries is accepted, works out the square root s, sets up
// the first block, then makes table reads, each through the RAM's registered
// read port and then a compare: up to about n/s block reads and up to s scan
// reads. Finally the result is handed over; the single RAM read port sets
// the pace. A search of an empty table goes straight to its miss result.
// The input is stalled while a search runs. A finished result sits in the
// output register, so a stalled receiver holds back only the next result; a
// following write or search is still taken. Reset clears the entry count and
// all control state; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module jump_search_sorted_table #(
    parameter int TABLE_DEPTH = jss_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = jss_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input transactions
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [jss_pkg::ADDR_W-1:0]   entry_address,
    input  logic [jss_pkg::KEY_IN_W-1:0] key,
    // Result transactions
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [jss_pkg::COUNT_W-1:0]  position,
    // Configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [jss_pkg::COUNT_W-1:0]  entry_count
);

    jss_pkg::cmd_t    cmd;
    jss_pkg::status_t status;

    // The count register is a plain flop, so a write can land in any cycle.
    assign cfg_ready = 1'b1;

    // The controller decides what happens each cycle; the datapath only acts
    // on its commands and on configuration writes, and reports comparisons back.
    jss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    jss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_count     (entry_count),
        .entry_address (entry_address),
        .key           (key),
        .cmd           (cmd),
        .status        (status),
        .found         (found),
        .position      (position)
    );

endmodule

### sv/jss_ram.sv
// ----------------------------------------------------------------------------
// Jump search sorted table: generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/jss_datapath.sv
// ----------------------------------------------------------------------------
// Jump search sorted table: datapath
// Holds the key table, the entry count, the square root unit, the block
// limit and scan base, and the result and output registers.
// ----------------------------------------------------------------------------
module jss_datapath #(
    parameter int TABLE_DEPTH = jss_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = jss_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [jss_pkg::COUNT_W-1:0]  cfg_count,
    input  logic [jss_pkg::ADDR_W-1:0]   entry_address,
    input  logic [jss_pkg::KEY_IN_W-1:0] key,
    input  jss_pkg::cmd_t                cmd,
    output jss_pkg::status_t             status,
    output logic                         found,
    output logic [jss_pkg::COUNT_W-1:0]  position
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RIW = (AW > jss_pkg::LIMIT_W) ? AW : jss_pkg::LIMIT_W;
    localparam int WIW = (AW > jss_pkg::ADDR_W) ? AW : jss_pkg::ADDR_W;

    logic [jss_pkg::MAX_KEY_W-1:0]  key_ext;
    logic [KEY_WIDTH-1:0]           key_m;
    logic [KEY_WIDTH-1:0]           key_reg;
    logic [jss_pkg::COUNT_W-1:0]    entry_count_reg;
    logic [jss_pkg::COUNT_W-1:0]    n_sat;
    logic [jss_pkg::LIMIT_W-1:0]    n_ext;
    logic [jss_pkg::ROOT_W-1:0]     root_reg;
    logic [jss_pkg::ROOT_BIT_W-1:0] bit_reg;
    logic [jss_pkg::ROOT_W-1:0]     trial;
    logic [2*jss_pkg::ROOT_W-1:0]   trial_sq;
    logic [jss_pkg::LIMIT_W-1:0]    limit_reg;
    logic [jss_pkg::LIMIT_W-1:0]    base_reg;
    logic [jss_pkg::LIMIT_W-1:0]    lim_min;
    logic [jss_pkg::LIMIT_W-1:0]    jump_pos;
    logic [jss_pkg::LIMIT_W-1:0]    rd_pos;
    logic [jss_pkg::LIMIT_W-1:0]    base_inc;
    logic [RIW-1:0]                 rd_pos_ext;
    logic [WIW-1:0]                 wr_pos_ext;
    logic                           ram_we;
    logic [KEY_WIDTH-1:0]           ram_rdata;
    logic                           res_found_reg;
    logic [jss_pkg::COUNT_W-1:0]    res_pos_reg;
    logic                           found_reg;
    logic [jss_pkg::COUNT_W-1:0]    position_reg;

    // Keys are kept at the table's width: truncated or zero extended.
    assign key_ext = jss_pkg::MAX_KEY_W'(key);
    assign key_m   = key_ext[KEY_WIDTH-1:0];

    // An entry count beyond the table saturates at the table depth.
    always_comb
    begin
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            n_sat = jss_pkg::COUNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = entry_count_reg;
        end
    end
    assign n_ext = jss_pkg::LIMIT_W'(n_sat);

    assign trial    = root_reg | (jss_pkg::ROOT_W'(1) << bit_reg);
    assign trial_sq = (2*jss_pkg::ROOT_W)'(trial) * (2*jss_pkg::ROOT_W)'(trial);

    assign lim_min  = (limit_reg < n_ext) ? limit_reg : n_ext;
    assign jump_pos = lim_min - jss_pkg::LIMIT_W'(1);
    assign rd_pos   = cmd.rd_scan ? base_reg : jump_pos;
    assign base_inc = base_reg + jss_pkg::LIMIT_W'(1);

    assign rd_pos_ext = RIW'(rd_pos);
    assign wr_pos_ext = WIW'(entry_address);
    assign ram_we     = cmd.write && (32'(entry_address) < 32'(TABLE_DEPTH));

    jss_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_key_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_pos_ext[AW-1:0]),
        .wdata (key_m),
        .raddr (rd_pos_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign status.empty      = (n_sat == '0);
    assign status.sqrt_last  = (bit_reg == '0);
    assign status.less       = (ram_rdata < key_reg);
    assign status.equal      = (ram_rdata == key_reg);
    assign status.limit_ge_n = (limit_reg >= n_ext);
    assign status.scan_end   = (base_inc == lim_min);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg  <= key_m;
            root_reg <= '0;
            bit_reg  <= jss_pkg::ROOT_BIT_W'(jss_pkg::ROOT_W - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (trial_sq <= (2*jss_pkg::ROOT_W)'(n_sat))
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg - jss_pkg::ROOT_BIT_W'(1);
        end

        if (cmd.jump_init)
        begin
            limit_reg <= jss_pkg::LIMIT_W'(root_reg);
            base_reg  <= '0;
        end
        else if (cmd.jump_adv)
        begin
            base_reg  <= limit_reg;
            limit_reg <= limit_reg + jss_pkg::LIMIT_W'(root_reg);
        end
        else if (cmd.scan_adv)
        begin
            base_reg <= base_inc;
        end

        if (cmd.res_hit)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= base_reg[jss_pkg::COUNT_W-1:0];
        end
        else if (cmd.res_miss)
        begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= n_sat;
        end

        if (cmd.out_load)
        begin
            found_reg    <= res_found_reg;
            position_reg <= res_pos_reg;
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

endmodule

### sv/jss_ctrl.sv
// ----------------------------------------------------------------------------
// Jump search sorted table: controller
// Sequences one transaction at a time, a write at once and a search through
// the square root, block jumps and linear scan; owns the output valid flag.
// ----------------------------------------------------------------------------
module jss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             operation,
    input  logic             out_stall,
    input  jss_pkg::status_t status,
    output jss_pkg::cmd_t    cmd,
    output logic             in_stall,
    output logic             out_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_JINIT = 3'd2;
    localparam logic [2:0] S_JREAD = 3'd3;
    localparam logic [2:0] S_JCMP  = 3'd4;
    localparam logic [2:0] S_SREAD = 3'd5;
    localparam logic [2:0] S_SCMP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == jss_pkg::OP_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (status.empty)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = S_JINIT;
                end
            end
            S_JINIT:
            begin
                cmd.jump_init = 1'b1;
                state_next    = S_JREAD;
            end
            S_JREAD:
            begin
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                if (status.less)
                begin
                    cmd.jump_adv = 1'b1;
                    if (status.limit_ge_n)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_JREAD;
                    end
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SREAD;
                end
            end
            S_SREAD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.rd_scan = 1'b1;
                if (status.less)
                begin
                    cmd.scan_adv = 1'b1;
                    if (status.scan_end)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SREAD;
                    end
                end
                else if (status.equal)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### bench/jump_search_sorted_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump search sorted table: regression bench
// Loads the key table through the input channel, programs the entry count,
// then runs directed searches and randomised traffic under several idling
// patterns. Every search result is checked against a jump search predictor
// held in the bench.
// ----------------------------------------------------------------------------
module jump_search_sorted_table_tb;

    localparam int TABLE_DEPTH      = jss_pkg::DEFAULT_TABLE_DEPTH;
    localparam int PHASE_COUNT      = 10;
    localparam int ITEMS_PER_PHASE  = 60;
    // A write retires as it is accepted, so a short pause suffices before a
    // configuration write; the end of the run allows for a whole search.
    localparam int SETTLE_CYCLES    = 16;
    localparam int FINAL_CYCLES     = 150;
    localparam int CYCLE_LIMIT      = 1_500_000;

    // Idling patterns, in percent of cycles.
    localparam int IDLE_PCT_SENDER   = 68;
    localparam int STALL_PCT_RECEIVE = 68;
    localparam int BOTH_PCT          = 25;

    typedef struct packed {
        logic                        found;
        logic [jss_pkg::COUNT_W-1:0] position;
    } search_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         operation     = jss_pkg::OP_WRITE;
    logic [jss_pkg::ADDR_W-1:0]   entry_address = '0;
    logic [jss_pkg::KEY_IN_W-1:0] key           = '0;
    logic                         out_stall     = 1'b0;
    logic                         cfg_valid     = 1'b0;
    logic [jss_pkg::COUNT_W-1:0]  entry_count   = '0;

    logic                         in_stall;
    logic                         out_valid;
    logic                         found;
    logic [jss_pkg::COUNT_W-1:0]  position;
    logic                         cfg_ready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    jump_search_sorted_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .entry_address (entry_address),
        .key           (key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .position      (position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .entry_count   (entry_count)
    );

    // ------------------------------------------------------------------------
    // The bench's own view of the block: the key table, the programmed entry
    // count and the search results still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    logic [jss_pkg::KEY_IN_W-1:0] key_table [TABLE_DEPTH];
    logic [jss_pkg::COUNT_W-1:0]  table_count = '0;
    search_result_t               search_results_due [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    int cycle_count = 0;
    int fail_count  = 0;
    int write_count = 0;
    int search_count = 0;
    int hit_count   = 0;
    int miss_count  = 0;
    int cfg_count   = 0;

    // Jump search over the first n entries, where n is the programmed count
    // clamped to the table depth. The stride is the integer square root of n.
    // The jump stops at the first block whose last entry is not below the key;
    // the scan then stops at the first entry not below the key, and only an
    // exact match there counts as found. A miss reports n as the position,
    // which is zero for an empty table.
    function automatic search_result_t jump_search_result(
        input logic [jss_pkg::KEY_IN_W-1:0] k);
        int n;
        int stride;
        int limit;
        int base;
        search_result_t r;
        n = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        r.found    = 1'b0;
        r.position = jss_pkg::COUNT_W'(n);
        if (n == 0)
            return r;
        stride = 0;
        while ((stride + 1) * (stride + 1) <= n)
            stride++;
        limit = stride;
        base  = 0;
        while (key_table[((limit < n) ? limit : n) - 1] < k)
        begin
            base  = limit;
            limit = limit + stride;
            if (base >= n)
                return r;
        end
        while (key_table[base] < k)
        begin
            base++;
            if (base == ((limit < n) ? limit : n))
                return r;
        end
        if (key_table[base] == k)
        begin
            r.found    = 1'b1;
            r.position = jss_pkg::COUNT_W'(base);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side. The stall is redrawn at every rising edge. Outputs are
    // sampled at the falling edge, where they hold the values that the next
    // rising edge will see, so a transaction is taken there without any race.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);

    always @(negedge clk)
    begin
        search_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (search_results_due.size() == 0)
            begin
                $error("result with no search outstanding: found %0d position %0d",
                       found, position);
                fail_count++;
            end
            else
            begin
                due = search_results_due.pop_front();
                if (found !== due.found)
                begin
                    $error("found: expected %0d, actual %0d", due.found, found);
                    fail_count++;
                end
                if (position !== due.position)
                begin
                    $error("position: expected %0d, actual %0d", due.position, position);
                    fail_count++;
                end
                if (due.found)
                    hit_count++;
                else
                    miss_count++;
            end
        end
    end

    // Guard against a hung block: the limit is several times the slowest
    // legal run of the whole stimulus.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Each task is entered and left at a rising edge, so that a
    // valid which stays high for the next transaction is assigned only once
    // in that time step.
    // ------------------------------------------------------------------------

    // Sends one input transaction, after a random idle gap when the current
    // pattern asks for one. The predictor is updated at the falling edge just
    // before the accepting rising edge, which keeps expectations in order.
    task automatic send_item(input logic op, input logic [jss_pkg::ADDR_W-1:0] addr,
                             input logic [jss_pkg::KEY_IN_W-1:0] k);
        bit stall_seen;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        entry_address <= addr;
        key           <= k;
        do
        begin
            @(negedge clk);
            stall_seen = in_stall;
            if (!stall_seen)
            begin
                if (op == jss_pkg::OP_WRITE)
                begin
                    key_table[addr] = k;
                    write_count++;
                end
                else
                begin
                    search_results_due.push_back(jump_search_result(k));
                    search_count++;
                end
            end
            @(posedge clk);
        end
        while (stall_seen);
    endtask

    // Lets the block go idle: every owed result in, then a short pause in
    // case the last transaction was a write, which produces no result.
    task automatic settle_block(input int pause);
        in_valid <= 1'b0;
        while (search_results_due.size() != 0)
            @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    // Programs the entry count. Only called once the block is idle.
    task automatic write_entry_count(input logic [jss_pkg::COUNT_W-1:0] value);
        bit ready_seen;
        cfg_valid   <= 1'b1;
        entry_count <= value;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid   <= 1'b0;
        table_count  = value;
        cfg_count++;
    endtask

    // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
    task automatic set_idling(input int mode);
        case (mode)
            1:
            begin
                tx_idle_pct  = IDLE_PCT_SENDER;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = STALL_PCT_RECEIVE;
            end
            3:
            begin
                tx_idle_pct  = BOTH_PCT;
                rx_stall_pct = BOTH_PCT;
            end
            default:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // With no entries in use a search must miss at position zero without
    // touching the table, which holds nothing yet.
    task automatic test_empty_table();
        write_entry_count('0);
        send_item(jss_pkg::OP_SEARCH, '1, '0);
        send_item(jss_pkg::OP_SEARCH, '0, '1);
        settle_block(SETTLE_CYCLES);
    endtask

    // A six-entry table with a run of duplicates and both key extremes:
    // the first of equal keys must be reported, and keys between entries
    // must miss. A one-entry table checks the smallest stride.
    task automatic test_small_table();
        send_item(jss_pkg::OP_WRITE, 10'd0, 32'h0000_0000);
        send_item(jss_pkg::OP_WRITE, 10'd1, 32'h0000_0007);
        send_item(jss_pkg::OP_WRITE, 10'd2, 32'h0000_0007);
        send_item(jss_pkg::OP_WRITE, 10'd3, 32'h0000_0007);
        send_item(jss_pkg::OP_WRITE, 10'd4, 32'h0000_0100);
        send_item(jss_pkg::OP_WRITE, 10'd5, 32'hFFFF_FFFF);
        settle_block(SETTLE_CYCLES);
        write_entry_count(11'd6);
        send_item(jss_pkg::OP_SEARCH, '0, 32'h0000_0000);
        send_item(jss_pkg::OP_SEARCH, '1, 32'h0000_0007);
        send_item(jss_pkg::OP_SEARCH, '0, 32'h0000_0100);
        send_item(jss_pkg::OP_SEARCH, '1, 32'hFFFF_FFFF);
        send_item(jss_pkg::OP_SEARCH, '0, 32'h0000_0050);
        send_item(jss_pkg::OP_SEARCH, '1, 32'hFFFF_FFFE);
        settle_block(SETTLE_CYCLES);
        write_entry_count(11'd1);
        send_item(jss_pkg::OP_SEARCH, '0, 32'h0000_0000);
        send_item(jss_pkg::OP_SEARCH, '0, 32'h0000_0001);
        settle_block(SETTLE_CYCLES);
    endtask

    // Fills every table position with ascending keys from zero to the top of
    // the key range, with the odd duplicate. After this no search can reach
    // an entry that was never written, whatever count is programmed.
    task automatic test_sorted_table_load();
        longint unsigned running_key;
        logic [jss_pkg::KEY_IN_W-1:0] k;
        running_key = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                k = '1;
            else
                k = jss_pkg::KEY_IN_W'(running_key);
            send_item(jss_pkg::OP_WRITE, jss_pkg::ADDR_W'(i), k);
            if ($urandom_range(15) != 0)
                running_key = running_key + $urandom_range(32'h007F_FFFF, 1);
            if (running_key > 64'hFFFF_FFFE)
                running_key = 64'hFFFF_FFFE;
        end
        settle_block(SETTLE_CYCLES);
    endtask

    // One random transaction. Searches mostly look for keys present in the
    // active part of the table or right next to them; writes mostly keep the
    // table in order, and a few drop in an arbitrary key so that the search
    // also runs over an unsorted table.
    task automatic send_random_item();
        int n_eff;
        int idx;
        int unsigned pick;
        logic [jss_pkg::ADDR_W-1:0]   addr;
        logic [jss_pkg::KEY_IN_W-1:0] k;
        logic [jss_pkg::KEY_IN_W-1:0] lower;
        logic [jss_pkg::KEY_IN_W-1:0] upper;
        n_eff = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        idx   = (n_eff > 0) ? $urandom_range(n_eff - 1) : 0;
        pick  = $urandom_range(99);
        if (pick < 25)
        begin
            if (n_eff > 0 && $urandom_range(3) != 0)
                addr = jss_pkg::ADDR_W'(idx);
            else
                addr = jss_pkg::ADDR_W'($urandom_range(TABLE_DEPTH - 1));
            lower = (addr == 0) ? '0 : key_table[addr - 1];
            upper = (addr == TABLE_DEPTH - 1) ? '1 : key_table[addr + 1];
            if ($urandom_range(4) == 0)
                k = $urandom;
            else if (lower <= upper)
                k = $urandom_range(upper, lower);
            else
                k = lower;
            send_item(jss_pkg::OP_WRITE, addr, k);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                k = key_table[idx];
            else if (pick < 70)
                k = $urandom_range(1) ? key_table[idx] + 1'b1 : key_table[idx] - 1'b1;
            else if (pick < 85)
                k = $urandom;
            else
                k = $urandom_range(1) ? '1 : '0;
            send_item(jss_pkg::OP_SEARCH,
                      jss_pkg::ADDR_W'($urandom_range(TABLE_DEPTH - 1)), k);
        end
    endtask

    // Randomised traffic over several entry counts: the full table, counts
    // past the depth that must saturate, empty, a single entry, a medium table
    // and small tables. The idling pattern rotates from phase to phase.
    task automatic test_random_traffic();
        logic [jss_pkg::COUNT_W-1:0] count_setting;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       count_setting = jss_pkg::COUNT_W'(TABLE_DEPTH);
                1:       count_setting = '1;
                2:       count_setting = '0;
                3:       count_setting = 11'd1;
                6:       count_setting = jss_pkg::COUNT_W'($urandom_range(TABLE_DEPTH - 1, 64));
                7:       count_setting = jss_pkg::COUNT_W'(
                                             $urandom_range(2046, TABLE_DEPTH + 1));
                default: count_setting = jss_pkg::COUNT_W'($urandom_range(63, 2));
            endcase
            settle_block(SETTLE_CYCLES);
            write_entry_count(count_setting);
            set_idling(phase % 4);
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Run sequence. Reset is held from time zero and released once.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_small_table();
        test_sorted_table_load();
        test_random_traffic();

        settle_block(FINAL_CYCLES);
        if (search_results_due.size() != 0)
        begin
            $error("%0d search results never arrived", search_results_due.size());
            fail_count++;
        end

        $display("Covered %0d table writes and %0d searches (%0d hits, %0d misses)",
                 write_count, search_count, hit_count, miss_count);
        $display("over %0d entry count settings, with and without idling and stalls.",
                 cfg_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
